// ===== hw/rtl/minimum_image_displacement_top_assert.svh =====
// Assertion macros for the minimum-image displacement block.
// Both expect clk and rst_n in scope.
`ifndef MINIMUM_IMAGE_DISPLACEMENT_TOP_ASSERT_SVH
`define MINIMUM_IMAGE_DISPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication
`define MID_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MID_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mid_pkg.sv =====
package mid_pkg;

    localparam int COORD_W   = 32;
    localparam int INNER_W   = 62;
    localparam int WIDE_W    = 63;
    localparam int NUM_W     = 64;
    localparam int QUO_W     = 63;
    localparam int DEN_W     = 31;
    localparam int DV_W      = 32;
    localparam int VEC_W     = 33;
    localparam int MAG_W     = 32;
    localparam int R2_W      = 63;
    localparam int ROOT_W    = 32;
    localparam int SQ_STEPS  = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [INNER_W-1:0] inner_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [VEC_W-1:0]   vec_t;

    localparam logic [DEN_W-1:0] BOX_LEN_RST = DEN_W'(10485760);

    // inner saturation bound is 2^61-1
    localparam inner_t INNER_MAX = {1'b0, {(INNER_W-1){1'b1}}};
    localparam inner_t INNER_MIN = -INNER_MAX;
    localparam wide_t  WIDE_MAX  = {2'b00, {(INNER_W-1){1'b1}}};
    localparam wide_t  WIDE_MIN  = -WIDE_MAX;

    // output coordinate range
    localparam inner_t COORD_MAX = inner_t'({1'b0, {(COORD_W-1){1'b1}}});
    localparam inner_t COORD_MIN = inner_t'(-COORD_MAX - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIODIC = 3'd0,
        CFG_BOX_AX   = 3'd1,
        CFG_BOX_BX   = 3'd2,
        CFG_BOX_BY   = 3'd3,
        CFG_BOX_CX   = 3'd4,
        CFG_BOX_CY   = 3'd5,
        CFG_BOX_CZ   = 3'd6
    } cfg_reg_t;

    // beat inside the wrapping stages
    typedef struct packed {
        logic             valid;
        logic             ov;
        inner_t [2:0]     d;
    } wrap_beat_t;

    // beat inside the square root stages
    typedef struct packed {
        logic                      valid;
        logic                      ov;
        logic [2:0][COORD_W-1:0]   d;
        logic [R2_W-1:0]           r2;
    } sqrt_beat_t;

endpackage

// ===== hw/rtl/mid_pair_if.sv =====
interface mid_pair_if;
    logic                               valid;
    logic                               ready;
    logic signed [mid_pkg::COORD_W-1:0] first_x;
    logic signed [mid_pkg::COORD_W-1:0] first_y;
    logic signed [mid_pkg::COORD_W-1:0] first_z;
    logic signed [mid_pkg::COORD_W-1:0] second_x;
    logic signed [mid_pkg::COORD_W-1:0] second_y;
    logic signed [mid_pkg::COORD_W-1:0] second_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

// ===== hw/rtl/mid_result_if.sv =====
interface mid_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [mid_pkg::COORD_W-1:0] delta_x;
    logic signed [mid_pkg::COORD_W-1:0] delta_y;
    logic signed [mid_pkg::COORD_W-1:0] delta_z;
    logic        [mid_pkg::R2_W-1:0]    dist_squared;
    logic        [mid_pkg::ROOT_W-1:0]  dist_res;
    logic                               overflow;

    modport source (
        output valid, delta_x, delta_y, delta_z, dist_squared, dist_res, overflow,
        input  ready
    );
    modport sink (
        input  valid, delta_x, delta_y, delta_z, dist_squared, dist_res, overflow,
        output ready
    );
endinterface

// ===== hw/rtl/mid_wrap.sv =====
// One wrap along a box vector: n = floor((2*key + den) / (2*den)),
// then d -= vec * n on all three axes, saturating at +-(2^61-1).
module mid_wrap (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  mid_pkg::wrap_beat_t              beat_in,
    input  mid_pkg::inner_t                  key,
    input  logic [mid_pkg::DEN_W-1:0]        den,
    input  mid_pkg::vec_t [2:0]              vec,
    output mid_pkg::wrap_beat_t              beat_out
);

    localparam int STEPS = mid_pkg::QUO_W;

    typedef struct packed {
        mid_pkg::wrap_beat_t          beat;
        logic                         neg;
        logic                         zero;
        logic [mid_pkg::DV_W-1:0]     rem;
        logic [mid_pkg::QUO_W-1:0]    uq;
    } div_t;

    logic [mid_pkg::NUM_W-1:0] num;
    logic [mid_pkg::DV_W-1:0]  dv;
    div_t                      prep_next;
    div_t                      div_reg  [0:STEPS];
    div_t                      div_next [1:STEPS];

    // prep: fold the sign so the divider sees a non-negative dividend
    assign dv  = {den, 1'b0};
    assign num = {key[mid_pkg::INNER_W-1], key, 1'b0}
               + {{(mid_pkg::NUM_W-mid_pkg::DEN_W){1'b0}}, den};

    always_comb
    begin
        prep_next.beat = beat_in;
        prep_next.neg  = num[mid_pkg::NUM_W-1];
        prep_next.zero = (den == '0);
        prep_next.rem  = '0;
        prep_next.uq   = num[mid_pkg::NUM_W-1] ? ~num[mid_pkg::QUO_W-1:0]
                                               : num[mid_pkg::QUO_W-1:0];
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin : div_steps
        logic [mid_pkg::DV_W:0] t;
        logic                   ge;
        for (int k = 0; k < STEPS; k++)
        begin
            t  = {div_reg[k].rem, div_reg[k].uq[mid_pkg::QUO_W-1]};
            ge = (t >= {1'b0, dv});
            div_next[k+1]     = div_reg[k];
            div_next[k+1].rem = ge ? mid_pkg::DV_W'(t - {1'b0, dv}) : t[mid_pkg::DV_W-1:0];
            div_next[k+1].uq  = {div_reg[k].uq[mid_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                div_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            div_reg[0] <= prep_next;
            for (int k = 1; k <= STEPS; k++)
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // wrap count as sign and magnitude; negative floor is -(q+1)
    mid_pkg::wrap_beat_t        n_beat_reg;
    logic [mid_pkg::QUO_W-1:0]  n_mag_reg;
    logic [mid_pkg::QUO_W-1:0]  n_mag_next;
    logic                       n_sign_reg;

    always_comb
    begin
        if (div_reg[STEPS].zero)
        begin
            n_mag_next = '0;
        end
        else if (div_reg[STEPS].neg)
        begin
            n_mag_next = mid_pkg::QUO_W'(div_reg[STEPS].uq + 1'b1);
        end
        else
        begin
            n_mag_next = div_reg[STEPS].uq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_beat_reg <= '0;
        end
        else if (adv)
        begin
            n_beat_reg <= div_reg[STEPS].beat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_mag_reg  <= n_mag_next;
            n_sign_reg <= div_reg[STEPS].neg && !div_reg[STEPS].zero;
        end
    end

    // partial products: |vec| times low and high halves of |n|
    mid_pkg::wrap_beat_t                    m1_beat_reg;
    logic [2:0][2*mid_pkg::MAG_W-1:0]       m1_lo_reg, m1_lo_next;
    logic [2:0][mid_pkg::QUO_W-1:0]         m1_hi_reg, m1_hi_next;
    logic [2:0]                             m1_neg_reg, m1_neg_next;

    always_comb
    begin : mul_part
        logic [mid_pkg::MAG_W-1:0] mv;
        for (int j = 0; j < 3; j++)
        begin
            mv = vec[j][mid_pkg::VEC_W-1] ? mid_pkg::MAG_W'(-vec[j])
                                          : mid_pkg::MAG_W'(vec[j]);
            m1_lo_next[j]  = (2*mid_pkg::MAG_W)'(mv)
                           * (2*mid_pkg::MAG_W)'(n_mag_reg[mid_pkg::MAG_W-1:0]);
            m1_hi_next[j]  = mid_pkg::QUO_W'(mv)
                           * mid_pkg::QUO_W'(n_mag_reg[mid_pkg::QUO_W-1:mid_pkg::MAG_W]);
            m1_neg_next[j] = vec[j][mid_pkg::VEC_W-1] ^ n_sign_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_beat_reg <= '0;
        end
        else if (adv)
        begin
            m1_beat_reg <= n_beat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_lo_reg  <= m1_lo_next;
            m1_hi_reg  <= m1_hi_next;
            m1_neg_reg <= m1_neg_next;
        end
    end

    // combine halves, saturate, apply sign
    mid_pkg::wrap_beat_t            m2_beat_reg;
    mid_pkg::inner_t [2:0]          m2_prod_reg, m2_prod_next;
    logic                           m2_sat_reg, m2_sat_next;

    always_comb
    begin : mul_join
        logic [2*mid_pkg::MAG_W:0] sum;
        logic                      over;
        mid_pkg::inner_t           p;
        m2_sat_next = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            sum  = {4'b0000, m1_hi_reg[j][28:0], {mid_pkg::MAG_W{1'b0}}}
                 + {1'b0, m1_lo_reg[j]};
            over = (|m1_hi_reg[j][mid_pkg::QUO_W-1:29])
                 || (sum > {3'b000, mid_pkg::INNER_MAX});
            p    = over ? mid_pkg::INNER_MAX : mid_pkg::inner_t'(sum[mid_pkg::INNER_W-1:0]);
            m2_prod_next[j] = m1_neg_reg[j] ? -p : p;
            m2_sat_next     = m2_sat_next | over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_beat_reg <= '0;
        end
        else if (adv)
        begin
            m2_beat_reg <= m1_beat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_prod_reg <= m2_prod_next;
            m2_sat_reg  <= m2_sat_next;
        end
    end

    // subtract and clamp
    mid_pkg::wrap_beat_t s_beat_reg, s_beat_next;

    always_comb
    begin : sub_clamp
        mid_pkg::wide_t diff;
        logic           ov;
        ov = m2_beat_reg.ov | m2_sat_reg;
        s_beat_next = m2_beat_reg;
        for (int j = 0; j < 3; j++)
        begin
            diff = $signed({m2_beat_reg.d[j][mid_pkg::INNER_W-1], m2_beat_reg.d[j]})
                 - $signed({m2_prod_reg[j][mid_pkg::INNER_W-1], m2_prod_reg[j]});
            if (diff > mid_pkg::WIDE_MAX)
            begin
                s_beat_next.d[j] = mid_pkg::INNER_MAX;
                ov = 1'b1;
            end
            else if (diff < mid_pkg::WIDE_MIN)
            begin
                s_beat_next.d[j] = mid_pkg::INNER_MIN;
                ov = 1'b1;
            end
            else
            begin
                s_beat_next.d[j] = diff[mid_pkg::INNER_W-1:0];
            end
        end
        s_beat_next.ov = ov;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_beat_reg <= '0;
        end
        else if (adv)
        begin
            s_beat_reg <= s_beat_next;
        end
    end

    assign beat_out = s_beat_reg;

endmodule

// ===== hw/rtl/mid_sqrt.sv =====
// Truncated square root of r2, one result bit per stage.
module mid_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  mid_pkg::sqrt_beat_t         beat_in,
    output mid_pkg::sqrt_beat_t         beat_out,
    output logic [mid_pkg::ROOT_W-1:0]  root
);

    localparam int ACC_W = 2*mid_pkg::ROOT_W;

    typedef struct packed {
        mid_pkg::sqrt_beat_t        beat;
        logic [mid_pkg::R2_W-1:0]   v;
        logic [ACC_W-1:0]           res;
    } sq_t;

    sq_t head;
    sq_t s_reg  [1:mid_pkg::SQ_STEPS];
    sq_t s_next [1:mid_pkg::SQ_STEPS];

    assign head.beat = beat_in;
    assign head.v    = beat_in.r2;
    assign head.res  = '0;

    always_comb
    begin : root_steps
        sq_t              cur;
        logic [ACC_W-1:0] bitv;
        logic [ACC_W-1:0] trial;
        for (int k = 0; k < mid_pkg::SQ_STEPS; k++)
        begin
            cur   = (k == 0) ? head : s_reg[k];
            bitv  = ACC_W'(1) << (2*(mid_pkg::SQ_STEPS-1-k));
            trial = cur.res + bitv;
            s_next[k+1] = cur;
            if ({1'b0, cur.v} >= trial)
            begin
                s_next[k+1].v   = mid_pkg::R2_W'({1'b0, cur.v} - trial);
                s_next[k+1].res = (cur.res >> 1) + bitv;
            end
            else
            begin
                s_next[k+1].res = cur.res >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= mid_pkg::SQ_STEPS; k++)
            begin
                s_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            for (int k = 1; k <= mid_pkg::SQ_STEPS; k++)
            begin
                s_reg[k] <= s_next[k];
            end
        end
    end

    assign beat_out = s_reg[mid_pkg::SQ_STEPS].beat;
    assign root     = s_reg[mid_pkg::SQ_STEPS].res[mid_pkg::ROOT_W-1:0];

endmodule

// ===== hw/rtl/minimum_image_displacement_top.sv =====
// Minimum-image displacement of a particle pair.
// pair: valid/ready channel carrying the coordinates of particles i and j.
// result: valid/ready channel carrying j minus i (wrapped when periodic mode
// is on), its squared length, its truncated length and an overflow flag.
// Config: write port (cfg_we, cfg_index, cfg_data), to be written only while
// idle by the user; the block does not enforce it. Throughput: one beat per
// cycle while the output is not stalled; pipeline of 239 register stages
// (difference, three wraps of 68 stages each, clamp/square, sum, 32 root
// stages). Each wrap is held to that depth by its 63-bit restoring divider,
// one quotient bit per stage; the root adds one stage per result bit.
// Stall: the whole pipeline holds while the output beat waits; pair.ready
// drops in the same cycle and nothing is lost or repeated.
// Reset: pipeline empties, periodic mode off, box diagonals 10.0, the
// off-diagonal terms zero.
`include "minimum_image_displacement_top_assert.svh"

module minimum_image_displacement_top (
    input  logic                              clk,
    input  logic                              rst_n,
    mid_pair_if.sink                          pair,
    mid_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [mid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mid_pkg::COORD_W-1:0]       cfg_data
);

    typedef struct packed {
        logic                                valid;
        logic                                ov;
        logic [2:0][mid_pkg::COORD_W-1:0]    d;
        logic [2:0][mid_pkg::R2_W-1:0]       sq;
    } sq_beat_t;

    logic                          adv;
    logic                          periodic_reg;
    logic [mid_pkg::DEN_W-1:0]     box_a_x_reg;
    logic [mid_pkg::COORD_W-1:0]   box_b_x_reg;
    logic [mid_pkg::DEN_W-1:0]     box_b_y_reg;
    logic [mid_pkg::COORD_W-1:0]   box_c_x_reg;
    logic [mid_pkg::COORD_W-1:0]   box_c_y_reg;
    logic [mid_pkg::DEN_W-1:0]     box_c_z_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periodic_reg <= 1'b0;
            box_a_x_reg  <= mid_pkg::BOX_LEN_RST;
            box_b_x_reg  <= '0;
            box_b_y_reg  <= mid_pkg::BOX_LEN_RST;
            box_c_x_reg  <= '0;
            box_c_y_reg  <= '0;
            box_c_z_reg  <= mid_pkg::BOX_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (mid_pkg::cfg_reg_t'(cfg_index))
                mid_pkg::CFG_PERIODIC: periodic_reg <= cfg_data[0];
                mid_pkg::CFG_BOX_AX:   box_a_x_reg  <= cfg_data[mid_pkg::DEN_W-1:0];
                mid_pkg::CFG_BOX_BX:   box_b_x_reg  <= cfg_data;
                mid_pkg::CFG_BOX_BY:   box_b_y_reg  <= cfg_data[mid_pkg::DEN_W-1:0];
                mid_pkg::CFG_BOX_CX:   box_c_x_reg  <= cfg_data;
                mid_pkg::CFG_BOX_CY:   box_c_y_reg  <= cfg_data;
                mid_pkg::CFG_BOX_CZ:   box_c_z_reg  <= cfg_data[mid_pkg::DEN_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: move when the output slot is free or being taken
    mid_pkg::sqrt_beat_t              out_beat;
    logic [mid_pkg::ROOT_W-1:0]       root;

    assign adv        = !out_beat.valid || result.ready;
    assign pair.ready = adv;

    // raw difference j minus i
    mid_pkg::wrap_beat_t d_beat_reg, d_beat_next;

    always_comb
    begin
        d_beat_next.valid = pair.valid;
        d_beat_next.ov    = 1'b0;
        d_beat_next.d[0]  = {{(mid_pkg::INNER_W-mid_pkg::COORD_W){pair.second_x[31]}}, pair.second_x}
                          - {{(mid_pkg::INNER_W-mid_pkg::COORD_W){pair.first_x[31]}}, pair.first_x};
        d_beat_next.d[1]  = {{(mid_pkg::INNER_W-mid_pkg::COORD_W){pair.second_y[31]}}, pair.second_y}
                          - {{(mid_pkg::INNER_W-mid_pkg::COORD_W){pair.first_y[31]}}, pair.first_y};
        d_beat_next.d[2]  = {{(mid_pkg::INNER_W-mid_pkg::COORD_W){pair.second_z[31]}}, pair.second_z}
                          - {{(mid_pkg::INNER_W-mid_pkg::COORD_W){pair.first_z[31]}}, pair.first_z};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_beat_reg <= '0;
        end
        else if (adv)
        begin
            d_beat_reg <= d_beat_next;
        end
    end

    // box vectors; a zero divisor disables that wrap
    mid_pkg::vec_t [2:0]           c_vec, b_vec, a_vec;
    logic [mid_pkg::DEN_W-1:0]     c_den, b_den, a_den;
    mid_pkg::wrap_beat_t           c_beat, b_beat, a_beat;

    assign c_vec[0] = {box_c_x_reg[mid_pkg::COORD_W-1], box_c_x_reg};
    assign c_vec[1] = {box_c_y_reg[mid_pkg::COORD_W-1], box_c_y_reg};
    assign c_vec[2] = {2'b00, box_c_z_reg};
    assign b_vec[0] = {box_b_x_reg[mid_pkg::COORD_W-1], box_b_x_reg};
    assign b_vec[1] = {2'b00, box_b_y_reg};
    assign b_vec[2] = '0;
    assign a_vec[0] = {2'b00, box_a_x_reg};
    assign a_vec[1] = '0;
    assign a_vec[2] = '0;

    assign c_den = periodic_reg ? box_c_z_reg : '0;
    assign b_den = periodic_reg ? box_b_y_reg : '0;
    assign a_den = periodic_reg ? box_a_x_reg : '0;

    mid_wrap u_wrap_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .beat_in  (d_beat_reg),
        .key      (d_beat_reg.d[2]),
        .den      (c_den),
        .vec      (c_vec),
        .beat_out (c_beat)
    );

    mid_wrap u_wrap_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .beat_in  (c_beat),
        .key      (c_beat.d[1]),
        .den      (b_den),
        .vec      (b_vec),
        .beat_out (b_beat)
    );

    mid_wrap u_wrap_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .beat_in  (b_beat),
        .key      (b_beat.d[0]),
        .den      (a_den),
        .vec      (a_vec),
        .beat_out (a_beat)
    );

    // clamp to coordinate range and square
    sq_beat_t f1_reg, f1_next;

    always_comb
    begin : clamp_sq
        mid_pkg::inner_t             c;
        logic [mid_pkg::MAG_W-1:0]   mag;
        logic                        ov;
        logic [2*mid_pkg::MAG_W-1:0] prod;
        ov = a_beat.ov;
        for (int j = 0; j < 3; j++)
        begin
            if ($signed(a_beat.d[j]) > mid_pkg::COORD_MAX)
            begin
                c  = mid_pkg::COORD_MAX;
                ov = 1'b1;
            end
            else if ($signed(a_beat.d[j]) < mid_pkg::COORD_MIN)
            begin
                c  = mid_pkg::COORD_MIN;
                ov = 1'b1;
            end
            else
            begin
                c = a_beat.d[j];
            end
            mag = c[mid_pkg::COORD_W-1] ? mid_pkg::MAG_W'(-c[mid_pkg::COORD_W-1:0])
                                        : c[mid_pkg::COORD_W-1:0];
            prod = (2*mid_pkg::MAG_W)'(mag) * (2*mid_pkg::MAG_W)'(mag);
            f1_next.d[j]  = c[mid_pkg::COORD_W-1:0];
            f1_next.sq[j] = prod[mid_pkg::R2_W-1:0];
        end
        f1_next.valid = a_beat.valid;
        f1_next.ov    = ov;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg <= '0;
        end
        else if (adv)
        begin
            f1_reg <= f1_next;
        end
    end

    // sum of squares, saturated to 63 bits
    mid_pkg::sqrt_beat_t f2_reg, f2_next;
    logic [mid_pkg::R2_W:0] sq_sum;

    assign sq_sum = (mid_pkg::R2_W+1)'(f1_reg.sq[0]) + (mid_pkg::R2_W+1)'(f1_reg.sq[1])
                  + (mid_pkg::R2_W+1)'(f1_reg.sq[2]);

    always_comb
    begin
        f2_next.valid = f1_reg.valid;
        f2_next.d     = f1_reg.d;
        f2_next.ov    = f1_reg.ov | sq_sum[mid_pkg::R2_W];
        f2_next.r2    = sq_sum[mid_pkg::R2_W] ? '1 : sq_sum[mid_pkg::R2_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_reg <= '0;
        end
        else if (adv)
        begin
            f2_reg <= f2_next;
        end
    end

    mid_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .beat_in  (f2_reg),
        .beat_out (out_beat),
        .root     (root)
    );

    // output beat
    assign result.valid        = out_beat.valid;
    assign result.delta_x      = out_beat.d[0];
    assign result.delta_y      = out_beat.d[1];
    assign result.delta_z      = out_beat.d[2];
    assign result.dist_squared = out_beat.r2;
    assign result.dist_res     = root;
    assign result.overflow     = out_beat.ov;

    // root bounds for the checks
    logic [2*mid_pkg::ROOT_W-1:0] root_lo_sq;
    logic [2*mid_pkg::ROOT_W:0]   root_hi_sq;
    logic [2*mid_pkg::ROOT_W:0]   root_inc;
    logic [2*mid_pkg::ROOT_W:0]   r2_ext;

    assign root_lo_sq = (2*mid_pkg::ROOT_W)'(result.dist_res)
                      * (2*mid_pkg::ROOT_W)'(result.dist_res);
    assign root_inc   = (2*mid_pkg::ROOT_W+1)'(result.dist_res) + 1'b1;
    assign root_hi_sq = root_inc * root_inc;
    assign r2_ext     = (2*mid_pkg::ROOT_W+1)'(result.dist_squared);

    `MID_ASSERT_NOW(a_root_low, result.valid, root_lo_sq <= r2_ext[2*mid_pkg::ROOT_W-1:0], "root too large")
    `MID_ASSERT_NOW(a_root_high, result.valid, root_hi_sq > r2_ext, "root too small")
    `MID_ASSERT_NOW(a_r2_sat, result.valid && (&result.dist_squared), result.overflow, "full-scale r2 without overflow")
    `MID_ASSERT_NEXT(a_stall_hold, !adv, $stable(f2_reg), "pipeline moved during stall")

endmodule
